[sv/key_change_to_midi_note_events_assert.svh]
// Assertion macros shared by the key scanner RTL.
`ifndef KEY_CHANGE_TO_MIDI_NOTE_EVENTS_ASSERT_SVH
`define KEY_CHANGE_TO_MIDI_NOTE_EVENTS_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define KCM_ASSERT_SAME(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error("kcm: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define KCM_ASSERT_NEXT(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error("kcm: next-cycle check failed");

`endif

[sv/kcm_pkg.sv]
// Shared constants and types for the key scanner to MIDI event block.
`timescale 1ns / 1ps

package kcm_pkg;

	localparam int PORT_W       = 8;
	localparam int STATUS_W     = 8;
	localparam int NOTE_W       = 7;
	localparam int VELOCITY_W   = 7;
	localparam int NOTE_MAP_W   = 56;
	localparam int CFG_INDEX_W  = 2;
	localparam int OUT_TDATA_W  = 24;

	localparam logic [STATUS_W-1:0]    STATUS_NOTE_ON  = 8'h90;
	localparam logic [STATUS_W-1:0]    STATUS_NOTE_OFF = 8'h80;
	localparam logic [VELOCITY_W-1:0]  VELOCITY_RESET  = 7'h45;

	localparam logic [CFG_INDEX_W-1:0] CFG_NOTE_MAP       = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_PRESS_VELOCITY = 2'd1;

	// What one key lane reports for the sample just taken.
	typedef struct packed {
		logic              changed;
		logic              level;
		logic [NOTE_W-1:0] note;
	} lane_result_t;

endpackage

[sv/kcm_lane.sv]
// One key lane: reads its pin, compares with the stored level, picks its note.
`timescale 1ns / 1ps

module kcm_lane #(
	parameter int BIT_POS = 0
) (
	input  logic [kcm_pkg::PORT_W-1:0] port_sample,
	input  logic                       prev_level,
	input  logic [kcm_pkg::NOTE_W-1:0] note,
	output kcm_pkg::lane_result_t      result
);

	logic level;

	generate
		if (BIT_POS < kcm_pkg::PORT_W) begin : g_pin
			assign level = port_sample[BIT_POS];
		end else begin : g_pullup
			// no pin behind this key: reads released
			assign level = 1'b1;
		end
	endgenerate

	assign result.changed = level ^ prev_level;
	assign result.level   = level;
	assign result.note    = note;

endmodule

[sv/kcm_emitter.sv]
// Merge stage: holds lane results and sends one message per changed key, lowest key first.
`timescale 1ns / 1ps

module kcm_emitter #(
	parameter int KEY_COUNT = 6
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 load,
	input  kcm_pkg::lane_result_t                lanes [KEY_COUNT],
	input  logic [kcm_pkg::VELOCITY_W-1:0]       press_velocity,
	output logic                                 busy,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [kcm_pkg::STATUS_W-1:0]         out_status,
	output logic [kcm_pkg::NOTE_W-1:0]           out_note,
	output logic [kcm_pkg::VELOCITY_W-1:0]       out_velocity,
	output logic                                 out_last
);

	logic [KEY_COUNT-1:0]      pending_q;
	logic [KEY_COUNT-1:0]      level_q;
	logic [kcm_pkg::NOTE_W-1:0] note_q [KEY_COUNT];

	logic [KEY_COUNT-1:0]       sel;
	logic [KEY_COUNT-1:0]       rest;
	logic [kcm_pkg::NOTE_W-1:0] pick_note;
	logic                       pick_level;
	logic                       advance;

	logic                           valid_q;
	logic [kcm_pkg::STATUS_W-1:0]   status_q;
	logic [kcm_pkg::NOTE_W-1:0]     onote_q;
	logic [kcm_pkg::VELOCITY_W-1:0] velocity_q;
	logic                           last_q;

	// lowest pending key as a one-hot
	assign sel  = pending_q & (~pending_q + KEY_COUNT'(1));
	assign rest = pending_q & ~sel;

	always_comb begin
		pick_note  = '0;
		pick_level = 1'b0;
		for (int i = 0; i < KEY_COUNT; i++) begin
			if (sel[i]) begin
				pick_note  = pick_note | note_q[i];
				pick_level = pick_level | level_q[i];
			end
		end
	end

	assign busy    = |pending_q;
	assign advance = busy && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (load) begin
			for (int i = 0; i < KEY_COUNT; i++) begin
				pending_q[i] <= lanes[i].changed;
			end
		end else if (advance) begin
			pending_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < KEY_COUNT; i++) begin
				level_q[i] <= lanes[i].level;
				note_q[i]  <= lanes[i].note;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			onote_q <= pick_note;
			last_q  <= ~|rest;
			if (pick_level) begin
				status_q   <= kcm_pkg::STATUS_NOTE_OFF;
				velocity_q <= '0;
			end else begin
				status_q   <= kcm_pkg::STATUS_NOTE_ON;
				velocity_q <= press_velocity;
			end
		end
	end

	assign out_valid    = valid_q;
	assign out_status   = status_q;
	assign out_note     = onote_q;
	assign out_velocity = velocity_q;
	assign out_last     = last_q;

endmodule

[sv/key_change_to_midi_note_events.sv]
// Key scanner top level: samples the key port and emits MIDI note-on/off messages.
//
// Each beat on s_axis is one sample of the 8-bit key port; key i sits on port bit
// KEY_BIT_OFFSET + i, active low, and a key beyond bit 7 reads released. One lane per
// key compares its pin with the stored level in the accept cycle; the merge stage then
// sends one three-field message per changed key, lowest key first, one per cycle while
// m_axis_tready is high, with tlast on the final message of the sample; s_axis_tready
// stays low while the merge stage still has messages to load into the output register.
// The output register lets a new sample in while the last message of the previous one
// waits. Config writes (index 0 note map, 7 bits per key; index 1 press velocity) are
// always taken; other indexes are dropped.
`timescale 1ns / 1ps

`include "key_change_to_midi_note_events_assert.svh"

module key_change_to_midi_note_events #(
	parameter int KEY_COUNT      = 6,
	parameter int KEY_BIT_OFFSET = 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// slave stream: tdata[7:0] port_sample
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [kcm_pkg::PORT_W-1:0]          s_axis_tdata,
	// master stream: tdata[7:0] status_byte, [14:8] note_number, [21:15] velocity
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [kcm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	output logic                                m_axis_tlast,
	// config write
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [kcm_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [kcm_pkg::NOTE_MAP_W-1:0]      cfg_data
);

	logic [kcm_pkg::NOTE_MAP_W-1:0] note_map_q;
	logic [kcm_pkg::VELOCITY_W-1:0] velocity_cfg_q;
	logic [KEY_COUNT-1:0]           prev_q;
	logic [KEY_COUNT-1:0]           new_levels;

	kcm_pkg::lane_result_t          lanes [KEY_COUNT];

	logic                           busy;
	logic                           in_beat;
	logic [kcm_pkg::STATUS_W-1:0]   out_status;
	logic [kcm_pkg::NOTE_W-1:0]     out_note;
	logic [kcm_pkg::VELOCITY_W-1:0] out_velocity;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_map_q     <= '0;
			velocity_cfg_q <= kcm_pkg::VELOCITY_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				kcm_pkg::CFG_NOTE_MAP:       note_map_q     <= cfg_data;
				kcm_pkg::CFG_PRESS_VELOCITY: velocity_cfg_q <=
					cfg_data[kcm_pkg::VELOCITY_W-1:0];
				default: ;
			endcase
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < KEY_COUNT; gi++) begin : g_lane
			kcm_lane #(
				.BIT_POS(KEY_BIT_OFFSET + gi)
			) u_lane (
				.port_sample(s_axis_tdata),
				.prev_level (prev_q[gi]),
				.note       (note_map_q[kcm_pkg::NOTE_W*gi +: kcm_pkg::NOTE_W]),
				.result     (lanes[gi])
			);
			assign new_levels[gi] = lanes[gi].level;
		end
	endgenerate

	assign s_axis_tready = !busy;
	assign in_beat       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '1;
		end else if (in_beat) begin
			prev_q <= new_levels;
		end
	end

	kcm_emitter #(
		.KEY_COUNT(KEY_COUNT)
	) u_emitter (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (in_beat),
		.lanes         (lanes),
		.press_velocity(velocity_cfg_q),
		.busy          (busy),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_status    (out_status),
		.out_note      (out_note),
		.out_velocity  (out_velocity),
		.out_last      (m_axis_tlast)
	);

	assign m_axis_tdata = {2'b00, out_velocity, out_note, out_status};

	// merge stage with work and a free output slot must fill the slot
	`KCM_ASSERT_NEXT(a_emit_when_free, busy && (!m_axis_tvalid || m_axis_tready), m_axis_tvalid)
	// a message that is not the last of its sample leaves work behind
	`KCM_ASSERT_SAME(a_more_after_nonlast, m_axis_tvalid && m_axis_tready && !m_axis_tlast, busy)
	// work only starts from an accepted sample
	`KCM_ASSERT_SAME(a_busy_from_beat, $rose(busy), $past(s_axis_tvalid && s_axis_tready))

endmodule

[tb/key_change_to_midi_note_events_tb.sv]
// Self-checking testbench for the key scanner to MIDI note event block.
`timescale 1ns / 1ps

module key_change_to_midi_note_events_tb;

	localparam int KEY_COUNT      = 6;
	localparam int KEY_BIT_OFFSET = 2;
	localparam int CLK_HALF       = 5;
	localparam int RESET_CYCLES   = 7;
	localparam int IDLE_SETTLE    = 12;
	localparam int DRAIN_CYCLES   = 24;
	localparam int CYCLE_LIMIT    = 300000;
	localparam int RAND_PHASES    = 6;
	localparam int PHASE_ITEMS    = 25;
	localparam int DIR_ROWS       = 23;

	// indexes with no register behind them
	localparam logic [kcm_pkg::CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [kcm_pkg::CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

	localparam logic [kcm_pkg::NOTE_MAP_W-1:0] NOTE_MAP_ONES = 56'hFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic [kcm_pkg::STATUS_W-1:0]   status;
		logic [kcm_pkg::NOTE_W-1:0]     note;
		logic [kcm_pkg::VELOCITY_W-1:0] vel;
		logic                           last;
	} midi_msg_t;

	typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t                       kind;
		logic [kcm_pkg::CFG_INDEX_W-1:0] cfg_idx;
		logic [kcm_pkg::NOTE_MAP_W-1:0]  cfg_val;
		logic [kcm_pkg::PORT_W-1:0]      smp;
		logic                            typed;
		logic                            t_count;
		midi_msg_t                       t_msg;
	} dir_row_t;

	localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
		// nothing changes right after reset
		'{ROW_SAMPLE, kcm_pkg::CFG_NOTE_MAP, 56'h0, 8'hFF, 1'b1, 1'b0, '0},
		'{ROW_SAMPLE, kcm_pkg::CFG_NOTE_MAP, 56'h0, 8'hFB, 1'b1, 1'b1,
			'{kcm_pkg::STATUS_NOTE_ON, 7'd0, kcm_pkg::VELOCITY_RESET, 1'b1}},
		'{ROW_SAMPLE, kcm_pkg::CFG_NOTE_MAP, 56'h0, 8'hFF, 1'b1, 1'b1,
			'{kcm_pkg::STATUS_NOTE_OFF, 7'd0, 7'd0, 1'b1}},
		'{ROW_CFG, kcm_pkg::CFG_NOTE_MAP, NOTE_MAP_ONES, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_CFG, kcm_pkg::CFG_PRESS_VELOCITY, 56'h7F, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, kcm_pkg::CFG_NOTE_MAP, 56'h0, 8'h7F, 1'b1, 1'b1,
			'{kcm_pkg::STATUS_NOTE_ON, 7'd127, 7'd127, 1'b1}},
		'{ROW_SAMPLE, kcm_pkg::CFG_NOTE_MAP, 56'h0, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, kcm_pkg::CFG_NOTE_MAP, 56'h0, 8'hFF, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, kcm_pkg::CFG_NOTE_MAP, 56'h0, 8'h03, 1'b0, 1'b0, '0},
		// only the bits below the key window move
		'{ROW_SAMPLE, kcm_pkg::CFG_NOTE_MAP, 56'h0, 8'h00, 1'b1, 1'b0, '0},
		'{ROW_SAMPLE, kcm_pkg::CFG_NOTE_MAP, 56'h0, 8'hFC, 1'b0, 1'b0, '0},
		'{ROW_CFG, kcm_pkg::CFG_NOTE_MAP, 56'h2468ACE13579BD, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_CFG, kcm_pkg::CFG_PRESS_VELOCITY, 56'h0, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, kcm_pkg::CFG_NOTE_MAP, 56'h0, 8'hEB, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, kcm_pkg::CFG_NOTE_MAP, 56'h0, 8'hAA, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, kcm_pkg::CFG_NOTE_MAP, 56'h0, 8'h55, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, kcm_pkg::CFG_NOTE_MAP, 56'h0, 8'hFF, 1'b0, 1'b0, '0},
		'{ROW_CFG, kcm_pkg::CFG_NOTE_MAP, 56'h0, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_CFG, kcm_pkg::CFG_PRESS_VELOCITY, 56'h1, 8'h00, 1'b0, 1'b0, '0},
		// writes to spare indexes must not touch either register
		'{ROW_CFG, CFG_SPARE_2, NOTE_MAP_ONES, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_CFG, CFG_SPARE_3, 56'h5A5A5A5A5A5A5A, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, kcm_pkg::CFG_NOTE_MAP, 56'h0, 8'hF7, 1'b1, 1'b1,
			'{kcm_pkg::STATUS_NOTE_ON, 7'd0, 7'd1, 1'b1}},
		'{ROW_SAMPLE, kcm_pkg::CFG_NOTE_MAP, 56'h0, 8'hFF, 1'b1, 1'b1,
			'{kcm_pkg::STATUS_NOTE_OFF, 7'd0, 7'd0, 1'b1}}
	};

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [kcm_pkg::PORT_W-1:0]      s_axis_tdata = '0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [kcm_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic                            m_axis_tlast;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [kcm_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [kcm_pkg::NOTE_MAP_W-1:0]  cfg_data = '0;

	// model state
	logic [KEY_COUNT-1:0]           key_levels;
	logic [kcm_pkg::NOTE_MAP_W-1:0] note_map_q;
	logic [kcm_pkg::VELOCITY_W-1:0] velocity_q;

	midi_msg_t expected_msgs[$];
	midi_msg_t sample_msgs[$];

	logic                       idling_on = 1'b1;
	int                         stall_left = 0;
	int                         cycle_count = 0;
	int                         mismatches = 0;
	int                         samples_sent = 0;
	int                         msgs_checked = 0;
	int                         cfg_writes = 0;
	logic [kcm_pkg::PORT_W-1:0] last_smp = 8'hFF;

	key_change_to_midi_note_events #(
		.KEY_COUNT(KEY_COUNT),
		.KEY_BIT_OFFSET(KEY_BIT_OFFSET)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("key_change_to_midi_note_events_tb NOT OK");
			$finish;
		end
	end

	// output side back-pressure
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idling_on && $urandom_range(0, 7) == 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= $urandom_range(0, 17);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		midi_msg_t exp_msg;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_msgs.size() == 0) begin
				$error("unexpected beat: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
				mismatches++;
			end else begin
				exp_msg = expected_msgs.pop_front();
				msgs_checked++;
				if (m_axis_tdata[7:0] !== exp_msg.status) begin
					$error("status_byte: expected %h actual %h",
						exp_msg.status, m_axis_tdata[7:0]);
					mismatches++;
				end
				if (m_axis_tdata[14:8] !== exp_msg.note) begin
					$error("note_number: expected %0d actual %0d",
						exp_msg.note, m_axis_tdata[14:8]);
					mismatches++;
				end
				if (m_axis_tdata[21:15] !== exp_msg.vel) begin
					$error("velocity: expected %0d actual %0d",
						exp_msg.vel, m_axis_tdata[21:15]);
					mismatches++;
				end
				if (m_axis_tlast !== exp_msg.last) begin
					$error("last_of_run: expected %b actual %b", exp_msg.last, m_axis_tlast);
					mismatches++;
				end
			end
		end
	end

	// one message per key whose level moved, lowest key first
	function automatic void predict_messages(input logic [kcm_pkg::PORT_W-1:0] smp);
		int        pos;
		logic      level;
		midi_msg_t m;
		sample_msgs.delete();
		for (int k = 0; k < KEY_COUNT; k++) begin
			pos = KEY_BIT_OFFSET + k;
			level = (pos >= kcm_pkg::PORT_W) ? 1'b1 : smp[pos];
			if (level != key_levels[k]) begin
				m.status = level ? kcm_pkg::STATUS_NOTE_OFF : kcm_pkg::STATUS_NOTE_ON;
				m.note = note_map_q[kcm_pkg::NOTE_W*k +: kcm_pkg::NOTE_W];
				m.vel = level ? '0 : velocity_q;
				m.last = 1'b0;
				key_levels[k] = level;
				sample_msgs.push_back(m);
			end
		end
		if (sample_msgs.size() != 0)
			sample_msgs[sample_msgs.size() - 1].last = 1'b1;
	endfunction

	task automatic send_sample(input logic [kcm_pkg::PORT_W-1:0] smp, input logic typed,
			input logic t_count, input midi_msg_t t_msg);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= smp;
		do @(posedge clk); while (!s_axis_tready);
		predict_messages(smp);
		samples_sent++;
		last_smp = smp;
		if (typed) begin
			if (t_count)
				expected_msgs.push_back(t_msg);
		end else begin
			foreach (sample_msgs[i])
				expected_msgs.push_back(sample_msgs[i]);
		end
	endtask

	task automatic write_config(input logic [kcm_pkg::CFG_INDEX_W-1:0] idx,
			input logic [kcm_pkg::NOTE_MAP_W-1:0] val);
		s_axis_tvalid <= 1'b0;
		while (expected_msgs.size() != 0) @(posedge clk);
		// a sample with no change leaves no beat to wait for
		repeat (IDLE_SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_writes++;
		case (idx)
			kcm_pkg::CFG_NOTE_MAP:       note_map_q = val;
			kcm_pkg::CFG_PRESS_VELOCITY: velocity_q = val[kcm_pkg::VELOCITY_W-1:0];
			default: ;
		endcase
	endtask

	function automatic logic [kcm_pkg::PORT_W-1:0] pick_sample();
		logic [kcm_pkg::PORT_W-1:0] smp;
		smp = last_smp;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				smp[KEY_BIT_OFFSET + $urandom_range(0, KEY_COUNT - 1)] ^= 1'b1;
				if ($urandom_range(0, 1))
					smp[KEY_BIT_OFFSET + $urandom_range(0, KEY_COUNT - 1)] ^= 1'b1;
			end
			6, 7: smp = kcm_pkg::PORT_W'($urandom);
			8: smp = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			default: smp[KEY_BIT_OFFSET-1:0] = KEY_BIT_OFFSET'($urandom);
		endcase
		return smp;
	endfunction

	initial begin
		logic [kcm_pkg::NOTE_MAP_W-1:0] map_val;
		logic [kcm_pkg::NOTE_MAP_W-1:0] vel_val;
		key_levels = '1;
		note_map_q = '0;
		velocity_q = kcm_pkg::VELOCITY_RESET;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[r]) begin
			if (DIRECTED_ROWS[r].kind == ROW_CFG)
				write_config(DIRECTED_ROWS[r].cfg_idx, DIRECTED_ROWS[r].cfg_val);
			else
				send_sample(DIRECTED_ROWS[r].smp, DIRECTED_ROWS[r].typed,
					DIRECTED_ROWS[r].t_count, DIRECTED_ROWS[r].t_msg);
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			map_val = kcm_pkg::NOTE_MAP_W'({$urandom, $urandom});
			vel_val = kcm_pkg::NOTE_MAP_W'({$urandom, $urandom});
			case (ph)
				1: begin
					map_val = NOTE_MAP_ONES;
					vel_val = '0;
				end
				2: begin
					map_val = '0;
					vel_val = NOTE_MAP_ONES;
				end
				3: begin
					write_config(CFG_SPARE_2, kcm_pkg::NOTE_MAP_W'({$urandom, $urandom}));
					write_config(CFG_SPARE_3, kcm_pkg::NOTE_MAP_W'({$urandom, $urandom}));
				end
				default: ;
			endcase
			write_config(kcm_pkg::CFG_NOTE_MAP, map_val);
			write_config(kcm_pkg::CFG_PRESS_VELOCITY, vel_val);
			// final phase runs back to back on both sides
			if (ph == RAND_PHASES - 1)
				idling_on <= 1'b0;
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_sample(pick_sample(), 1'b0, 1'b0, '0);
		end

		s_axis_tvalid <= 1'b0;
		while (expected_msgs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d port samples and %0d register writes.",
			samples_sent, cfg_writes);
		$display("Checked %0d note messages, %0d mismatches.", msgs_checked, mismatches);
		if (mismatches == 0)
			$display("key_change_to_midi_note_events_tb OK");
		else
			$display("key_change_to_midi_note_events_tb NOT OK");
		$finish;
	end

endmodule

[sim.f]
+incdir+sv
sv/kcm_pkg.sv
sv/kcm_lane.sv
sv/kcm_emitter.sv
sv/key_change_to_midi_note_events.sv
tb/key_change_to_midi_note_events_tb.sv
